// ----- rtl/core/tcfp_pkg.sv -----
// Shared types and constants for the tuning command frame parser.
package tcfp_pkg;

  // Frame syntax characters
  localparam logic [7:0] CH_AT    = 8'h40; // '@'
  localparam logic [7:0] CH_HASH  = 8'h23; // '#'
  localparam logic [7:0] CH_EQ    = 8'h3D; // '='
  localparam logic [7:0] CH_MINUS = 8'h2D; // '-'
  localparam logic [7:0] CH_PLUS  = 8'h2B; // '+'
  localparam logic [7:0] CH_DOT   = 8'h2E; // '.'
  localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
  localparam logic [7:0] CH_NINE  = 8'h39; // '9'

  // Letters of the fixed commands
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_U = 8'h55;
  localparam logic [7:0] CH_V = 8'h56;

  // Value limits
  localparam logic [29:0] MAG_LIMIT  = 30'd999999999;
  localparam logic [3:0]  FRAC_LIMIT = 4'd8;

  // Configuration register map
  localparam int          CFG_ADDR_W        = 3;
  localparam logic        REG_MAX_FRAME_LEN = 1'b0;  // register index, paddr[2]
  localparam logic [3:0]  MAX_LEN_RESET     = 4'd14;

  // Stream data widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 64;

  // One decoded command
  typedef struct packed {
    logic [3:0]  fraction_digits;
    logic [30:0] value_digits;
    logic [7:0]  key_third;
    logic [7:0]  key_second;
    logic [7:0]  key_first;
  } result_t;

endpackage

// ----- rtl/core/tcfp_cfg.sv -----
// APB-style register port holding the frame length limit.
module tcfp_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [tcfp_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready,
  output logic [3:0]                          max_frame_len
);

  logic [3:0] max_len_r;
  logic [3:0] max_len_nxt;
  logic       wr_en;
  logic       sel_len;

  assign cfg_pready = 1'b1;
  assign sel_len    = (cfg_paddr[2] == tcfp_pkg::REG_MAX_FRAME_LEN);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // register write
  always_comb begin
    max_len_nxt = max_len_r;
    if (wr_en && sel_len) begin
      max_len_nxt = cfg_pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= tcfp_pkg::MAX_LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  // read back
  assign cfg_prdata    = sel_len ? {28'd0, max_len_r} : 32'd0;
  assign max_frame_len = max_len_r;

endmodule

// ----- rtl/core/tcfp_parse.sv -----
// Frame tracker and value accumulator; decodes a frame on its closing '#'.
module tcfp_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_en,      // a word is accepted this cycle
  input  logic [7:0]          rx_byte,
  input  logic [3:0]          max_frame_len,
  output logic                res_push,     // decoded result this cycle
  output tcfp_pkg::result_t   res_data
);

  logic        in_frame_r,  in_frame_nxt;
  logic [3:0]  count_r,     count_nxt;
  logic [23:0] key_r,       key_nxt;
  logic [7:0]  fifth_r,     fifth_nxt;
  logic        neg_r,       neg_nxt;
  logic [29:0] acc_r,       acc_nxt;
  logic [3:0]  frac_r,      frac_nxt;
  logic        point_r,     point_nxt;
  logic        ended_r,     ended_nxt;

  logic [7:0]  ka, kb, kc;
  logic        is_digit;
  logic [3:0]  digit;
  logic [33:0] acc_x10;
  logic [31:0] acc_next;
  logic        over_mag;
  logic        is_stp, is_run, is_sav, is_kv;

  assign ka = key_r[7:0];
  assign kb = key_r[15:8];
  assign kc = key_r[23:16];

  // digit step: acc*10 + d, kept to 32 bits
  assign is_digit = (rx_byte >= tcfp_pkg::CH_ZERO) && (rx_byte <= tcfp_pkg::CH_NINE);
  assign digit    = rx_byte[3:0];
  assign acc_x10  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0};
  assign acc_next = acc_x10[31:0] + {28'd0, digit};
  assign over_mag = acc_next > {2'b00, tcfp_pkg::MAG_LIMIT};

  // command forms, judged on the stored length
  assign is_stp = ((count_r == 4'd5) && (ka == tcfp_pkg::CH_S) && (kb == tcfp_pkg::CH_T) &&
                   (kc == tcfp_pkg::CH_O) && (fifth_r == tcfp_pkg::CH_P)) ||
                  ((count_r == 4'd4) && (ka == tcfp_pkg::CH_S) && (kb == tcfp_pkg::CH_T) &&
                   (kc == tcfp_pkg::CH_P));
  assign is_run = (count_r == 4'd4) && (ka == tcfp_pkg::CH_R) && (kb == tcfp_pkg::CH_U) &&
                  (kc == tcfp_pkg::CH_N);
  assign is_sav = (count_r == 4'd4) && (ka == tcfp_pkg::CH_S) && (kb == tcfp_pkg::CH_A) &&
                  (kc == tcfp_pkg::CH_V);
  assign is_kv  = (count_r >= 4'd6) && (fifth_r == tcfp_pkg::CH_EQ);

  // decoded fields
  always_comb begin
    res_data.key_first       = ka;
    res_data.key_second      = kb;
    res_data.key_third       = kc;
    res_data.value_digits    = neg_r ? (31'd0 - {1'b0, acc_r}) : {1'b0, acc_r};
    res_data.fraction_digits = frac_r;
    if (is_stp) begin
      res_data.key_first       = tcfp_pkg::CH_S;
      res_data.key_second      = tcfp_pkg::CH_T;
      res_data.key_third       = tcfp_pkg::CH_P;
      res_data.value_digits    = 31'd1;
      res_data.fraction_digits = 4'd0;
    end else if (is_run || is_sav) begin
      res_data.value_digits    = 31'd0;
      res_data.fraction_digits = 4'd0;
    end
  end

  // per-byte state update
  always_comb begin
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    key_nxt      = key_r;
    fifth_nxt    = fifth_r;
    neg_nxt      = neg_r;
    acc_nxt      = acc_r;
    frac_nxt     = frac_r;
    point_nxt    = point_r;
    ended_nxt    = ended_r;
    res_push     = 1'b0;
    if (byte_en) begin
      if (rx_byte == tcfp_pkg::CH_AT) begin
        // start or restart a frame
        in_frame_nxt = 1'b1;
        count_nxt    = 4'd1;
        key_nxt      = 24'd0;
        fifth_nxt    = 8'd0;
        neg_nxt      = 1'b0;
        acc_nxt      = 30'd0;
        frac_nxt     = 4'd0;
        point_nxt    = 1'b0;
        ended_nxt    = 1'b0;
      end else if (in_frame_r) begin
        if (count_r >= max_frame_len) begin
          // too long: drop the frame
          in_frame_nxt = 1'b0;
          count_nxt    = 4'd0;
        end else if (rx_byte == tcfp_pkg::CH_HASH) begin
          in_frame_nxt = 1'b0;
          count_nxt    = 4'd0;
          res_push     = is_stp | is_run | is_sav | is_kv;
        end else begin
          count_nxt = count_r + 4'd1;
          if (count_r == 4'd1) begin
            key_nxt[7:0] = rx_byte;
          end else if (count_r == 4'd2) begin
            key_nxt[15:8] = rx_byte;
          end else if (count_r == 4'd3) begin
            key_nxt[23:16] = rx_byte;
          end else if (count_r == 4'd4) begin
            fifth_nxt = rx_byte;
          end else if (count_r >= 4'd5) begin
            // value text
            if ((count_r == 4'd5) && (rx_byte == tcfp_pkg::CH_MINUS)) begin
              neg_nxt = 1'b1;
            end else if ((count_r == 4'd5) && (rx_byte == tcfp_pkg::CH_PLUS)) begin
              neg_nxt = neg_r;
            end else if (ended_r) begin
              ended_nxt = 1'b1;
            end else if (rx_byte == tcfp_pkg::CH_DOT) begin
              point_nxt = 1'b1;
            end else if (!is_digit) begin
              ended_nxt = 1'b1;
            end else if (point_r) begin
              if ((frac_r < tcfp_pkg::FRAC_LIMIT) && !over_mag) begin
                acc_nxt  = acc_next[29:0];
                frac_nxt = frac_r + 4'd1;
              end
            end else begin
              acc_nxt = over_mag ? tcfp_pkg::MAG_LIMIT : acc_next[29:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= 4'd0;
      key_r      <= 24'd0;
      fifth_r    <= 8'd0;
      neg_r      <= 1'b0;
      acc_r      <= 30'd0;
      frac_r     <= 4'd0;
      point_r    <= 1'b0;
      ended_r    <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      key_r      <= key_nxt;
      fifth_r    <= fifth_nxt;
      neg_r      <= neg_nxt;
      acc_r      <= acc_nxt;
      frac_r     <= frac_nxt;
      point_r    <= point_nxt;
      ended_r    <= ended_nxt;
    end
  end

endmodule

// ----- rtl/core/tcfp_outbuf.sv -----
// Result register with a skid stage so input keeps flowing under output stalls.
module tcfp_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tcfp_pkg::result_t   push_data,
  output logic                space,        // room for one more result
  output logic                out_valid,
  input  logic                out_ready,
  output tcfp_pkg::result_t   out_data
);

  logic              main_vld_r, main_vld_nxt;
  logic              skid_vld_r, skid_vld_nxt;
  tcfp_pkg::result_t main_r,     main_nxt;
  tcfp_pkg::result_t skid_r,     skid_nxt;
  logic              pop;

  assign pop = main_vld_r & out_ready;

  // two-entry queue: main register feeds the port, skid catches overflow
  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (pop) begin
      if (skid_vld_r) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end else if (push) begin
        main_nxt = push_data;
      end else begin
        main_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_vld_r) begin
        main_nxt     = push_data;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_data;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign space     = ~skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

endmodule

// ----- rtl/core/tuning_command_frame_parser.sv -----
// Top level of the tuning command frame parser.
//
//  channel | direction | payload
//  --------+-----------+-------------------------------------------------------
//  in_     | slave     | tdata[7:0] rx_byte
//  out_    | master    | tdata: key_first, key_second, key_third, value_digits,
//          |           |        fraction_digits (zero padded to 64 bits)
//  cfg_    | APB slave | reg 0 @ 0x0: max_frame_len[3:0]
//
// One word is taken every cycle while in_tready is high; frame state updates in
// the accept cycle and a decoded command is registered into the output register,
// or into the skid entry while that register still holds an untaken result. A
// two-entry result queue (output register plus skid) keeps in_tready high until
// both entries hold undelivered results under output stall. Reset (synchronous,
// rst_n low) closes any open frame, empties the queue and sets max_frame_len to 14.
module tuning_command_frame_parser (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [tcfp_pkg::IN_DATA_W-1:0]        in_tdata,   // [7:0] rx_byte
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [7:0] key_first, [15:8] key_second, [23:16] key_third,
  // [54:24] value_digits, [58:55] fraction_digits, [63:59] zero
  output logic [tcfp_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [tcfp_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);

  logic              byte_en;
  logic [3:0]        max_frame_len;
  logic              res_push;
  tcfp_pkg::result_t res_data;
  tcfp_pkg::result_t out_data;

  assign byte_en = in_tvalid & in_tready;

  tcfp_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .max_frame_len (max_frame_len)
  );

  tcfp_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_en       (byte_en),
    .rx_byte       (in_tdata),
    .max_frame_len (max_frame_len),
    .res_push      (res_push),
    .res_data      (res_data)
  );

  tcfp_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .space     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data)
  );

  // pack result word, lowest field first
  assign out_tdata = {5'd0, out_data};

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the tuning command frame parser.
`timescale 1ns / 100ps

module tb;
  import tcfp_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_LEN  = {REG_MAX_FRAME_LEN, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = {~REG_MAX_FRAME_LEN, 2'b00};
  localparam int STALL_LIMIT = 2000;
  localparam int N_DIR = 23;
  localparam int N_PHASE = 5;

  typedef enum {ROW_PRED, ROW_RESULT, ROW_NONE} row_kind_t;

  // one directed frame; key/val/frac only used for ROW_RESULT
  typedef struct {
    string     text;
    row_kind_t kind;
    string     key;
    int        val;
    int        frac;
  } dir_row_t;

  logic                    clk;
  logic                    rst_n       = 1'b0;
  logic                    in_tvalid   = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata    = '0;   // [7:0] rx_byte
  logic                    out_tvalid;
  logic                    out_tready  = 1'b0;
  // [7:0] key_first, [15:8] key_second, [23:16] key_third,
  // [54:24] value_digits, [58:55] fraction_digits, [63:59] zero
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    cfg_psel    = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_paddr   = '0;
  logic [31:0]             cfg_pwdata  = '0;
  logic [31:0]             cfg_prdata;
  logic                    cfg_pready;

  tuning_command_frame_parser uut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  int       errors      = 0;
  int       idle_pct    = 13;
  int       idle_cycles = 0;
  result_t  pending_cmds [$];
  result_t  cmd_got, cmd_want;
  dir_row_t dir_rows [N_DIR];

  logic [3:0] phase_len   [N_PHASE] = '{4'd15, 4'd6, 4'd5, 4'd11, 4'd15};
  int         phase_words [N_PHASE] = '{220, 130, 90, 170, 220};
  int         phase_idle  [N_PHASE] = '{13, 13, 13, 0, 13};

  // Parser shadow state
  logic [3:0]       lim_len = MAX_LEN_RESET;
  bit               fr_open = 1'b0;
  logic [3:0]       fr_count = '0;
  logic [2:0][7:0]  fr_key = '0;
  logic [7:0]       fr_fifth = '0;
  bit               fr_neg = 1'b0;
  logic [29:0]      fr_mag = '0;
  logic [3:0]       fr_frac = '0;
  bit               fr_point = 1'b0;
  bit               fr_ended = 1'b0;

  // Advance the shadow parser by one byte; returns 1 when a command is decoded
  function automatic bit parse_byte(input logic [7:0] c, output result_t cmd);
    logic [3:0]  len;
    logic [31:0] nxt;
    cmd = '0;
    if (c == CH_AT) begin
      fr_open  = 1'b1;
      fr_count = 4'd1;
      fr_key   = '0;
      fr_fifth = '0;
      fr_neg   = 1'b0;
      fr_mag   = '0;
      fr_frac  = '0;
      fr_point = 1'b0;
      fr_ended = 1'b0;
      return 1'b0;
    end
    if (!fr_open) return 1'b0;
    // length limit wins over the terminator
    if (fr_count >= lim_len) begin
      fr_open  = 1'b0;
      fr_count = '0;
      return 1'b0;
    end
    if (c == CH_HASH) begin
      len      = fr_count;
      fr_open  = 1'b0;
      fr_count = '0;
      if ((len == 4'd5 && fr_key == {CH_O, CH_T, CH_S} && fr_fifth == CH_P) ||
          (len == 4'd4 && fr_key == {CH_P, CH_T, CH_S})) begin
        cmd = {4'd0, 31'd1, CH_P, CH_T, CH_S};
        return 1'b1;
      end
      if (len == 4'd4 && (fr_key == {CH_N, CH_U, CH_R} || fr_key == {CH_V, CH_A, CH_S})) begin
        cmd = {35'd0, fr_key};
        return 1'b1;
      end
      if (len < 4'd6 || fr_fifth != CH_EQ) return 1'b0;
      cmd.key_first       = fr_key[0];
      cmd.key_second      = fr_key[1];
      cmd.key_third       = fr_key[2];
      cmd.value_digits    = fr_neg ? 31'd0 - 31'(fr_mag) : 31'(fr_mag);
      cmd.fraction_digits = fr_frac;
      return 1'b1;
    end
    if (fr_count >= 4'd1 && fr_count <= 4'd3) begin
      fr_key[fr_count - 4'd1] = c;
    end else if (fr_count == 4'd4) begin
      fr_fifth = c;
    end else if (fr_count >= 4'd5) begin
      // value text: sign only in the lead position, dots after the first skipped
      if (fr_count == 4'd5 && c == CH_MINUS) begin
        fr_neg = 1'b1;
      end else if (fr_count == 4'd5 && c == CH_PLUS) begin
      end else if (!fr_ended) begin
        if (c == CH_DOT) begin
          fr_point = 1'b1;
        end else if (c < CH_ZERO || c > CH_NINE) begin
          fr_ended = 1'b1;
        end else begin
          // digit step wraps at 32 bits
          nxt = 32'(fr_mag) * 32'd10 + 32'(c - CH_ZERO);
          if (fr_point) begin
            if (fr_frac < FRAC_LIMIT && nxt <= 32'(MAG_LIMIT)) begin
              fr_mag  = nxt[29:0];
              fr_frac = fr_frac + 4'd1;
            end
          end else begin
            fr_mag = (nxt > 32'(MAG_LIMIT)) ? MAG_LIMIT : nxt[29:0];
          end
        end
      end
    end
    fr_count = fr_count + 4'd1;
    return 1'b0;
  endfunction

  // Push one word into the parser, with random gaps before it
  task automatic send_word(input logic [7:0] b, input bit use_pred);
    result_t cmd;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (parse_byte(b, cmd) && use_pred) pending_cmds.push_back(cmd);
  endtask

  // APB write, or read-back of the length register
  task automatic reg_access(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (wr) begin
      if (addr[2] == REG_MAX_FRAME_LEN) lim_len = data[3:0];
    end else if (cfg_prdata[3:0] !== lim_len) begin
      errors++;
      $display("%0t: max_frame_len read expected %0d, got %0d", $time, lim_len,
               cfg_prdata[3:0]);
    end
  endtask

  // Hold off input until every pending command is out, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random frame: mostly well formed key=value or fixed commands, some noise
  task automatic make_frame(output logic [7:0] fr[$]);
    int unsigned pick, n, room, mode;
    logic [7:0]  c;
    string       fixed;
    fr = {};
    pick = $urandom_range(99);
    if (pick < 15) begin
      // noise, or a frame that never gets its terminator
      n = $urandom_range(8, 1);
      if ($urandom_range(1)) fr.push_back(CH_AT);
      repeat (n) fr.push_back(8'($urandom_range(255)));
    end else if (pick < 32) begin
      case ($urandom_range(6))
        0: fixed = "STOP";
        1: fixed = "STP";
        2: fixed = "RUN";
        3: fixed = "SAV";
        4: fixed = "RUNS";
        5: fixed = "STO";
        default: fixed = "SA";
      endcase
      fr.push_back(CH_AT);
      for (int i = 0; i < fixed.len(); i++) fr.push_back(fixed[i]);
      if ($urandom_range(9) != 0) fr.push_back(CH_HASH);
    end else begin
      fr.push_back(CH_AT);
      repeat (3) begin
        pick = $urandom_range(19);
        if (pick == 0)      c = 8'h00;
        else if (pick == 1) c = 8'hFF;
        else if (pick == 2) c = 8'($urandom_range(255));
        else                c = 8'($urandom_range("Z", "A"));
        fr.push_back(c);
      end
      fr.push_back(($urandom_range(15) == 0) ? 8'($urandom_range(255)) : CH_EQ);
      room = (lim_len >= 4'd6) ? lim_len - 4'd6 : 0;
      // mode 0: all nines, mode 1: point first, else mixed text
      mode = $urandom_range(7);
      if (mode < 2)                    n = room;
      else if ($urandom_range(7) == 0) n = $urandom_range(room + 2);
      else                             n = $urandom_range(room);
      for (int i = 0; i < n; i++) begin
        pick = $urandom_range(99);
        if (mode == 0)                 c = CH_NINE;
        else if (mode == 1 && i == 0)  c = CH_DOT;
        else if (mode == 1)            c = 8'($urandom_range(CH_NINE, CH_ZERO));
        else if (i == 0 && pick < 30)  c = (pick < 18) ? CH_MINUS : CH_PLUS;
        else if (pick < 78)            c = 8'($urandom_range(CH_NINE, CH_ZERO));
        else if (pick < 90)            c = CH_DOT;
        else                           c = 8'($urandom_range(255));
        fr.push_back(c);
      end
      if ($urandom_range(15) != 0) fr.push_back(CH_HASH);
    end
  endtask

  task automatic check_field(input string name, input logic [30:0] want,
                             input logic [30:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Output ready, same idle rate as the sender
  always @(posedge clk) out_tready <= ($urandom_range(99) >= idle_pct);

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      cmd_got = out_tdata[$bits(result_t)-1:0];
      if (pending_cmds.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got %h", $time, out_tdata);
      end else begin
        cmd_want = pending_cmds.pop_front();
        check_field("key_first", 31'(cmd_want.key_first), 31'(cmd_got.key_first));
        check_field("key_second", 31'(cmd_want.key_second), 31'(cmd_got.key_second));
        check_field("key_third", 31'(cmd_want.key_third), 31'(cmd_got.key_third));
        check_field("value_digits", cmd_want.value_digits, cmd_got.value_digits);
        check_field("fraction_digits", 31'(cmd_want.fraction_digits),
                    31'(cmd_got.fraction_digits));
      end
    end
  end

  // Watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim
    result_t    cmd;
    logic [7:0] frame [$];
    int         sent;

    dir_rows = '{
      '{"@STOP#",              ROW_RESULT, "STP", 1, 0},
      '{"@STP#",               ROW_RESULT, "STP", 1, 0},
      '{"@RUN#",               ROW_RESULT, "RUN", 0, 0},
      '{"@SAV#",               ROW_RESULT, "SAV", 0, 0},
      '{"@STOPX#",             ROW_NONE,   "",    0, 0},
      '{"@SAVE#",              ROW_NONE,   "",    0, 0},
      '{"@ABC=#",              ROW_NONE,   "",    0, 0},
      '{"@KEY=-#",             ROW_RESULT, "KEY", 0, 0},
      '{"@ABC=0#",             ROW_RESULT, "ABC", 0, 0},
      '{"@NEG=-0#",            ROW_RESULT, "NEG", 0, 0},
      '{"@MAX=12345678#",      ROW_RESULT, "MAX", 12345678, 0},
      '{"@LIM=123456789#",     ROW_NONE,   "",    0, 0},
      '{"@FRC=.1234567#",      ROW_RESULT, "FRC", 1234567, 7},
      '{"@MIN=-9999999#",      ROW_RESULT, "MIN", -9999999, 0},
      '{"xyz#=9#",             ROW_NONE,   "",    0, 0},
      '{"@KP@KPX=-2.5#",       ROW_PRED,   "",    0, 0},
      '{"@ABC=1.2.3#",         ROW_PRED,   "",    0, 0},
      '{"@ABC=+42x9#",         ROW_PRED,   "",    0, 0},
      '{"@ABC=-.5#",           ROW_PRED,   "",    0, 0},
      '{"@#",                  ROW_NONE,   "",    0, 0},
      '{"@\377\200\001=-9.09#", ROW_PRED,  "",    0, 0},
      '{"@ABC=12-3#",          ROW_PRED,   "",    0, 0},
      '{"@ABCDEFGHIJKLMN#",    ROW_NONE,   "",    0, 0}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reg_access(1'b0, ADDR_MAX_LEN, '0);

    // Directed frames at the reset length limit
    foreach (dir_rows[r]) begin
      for (int i = 0; i < dir_rows[r].text.len(); i++)
        send_word(dir_rows[r].text[i], dir_rows[r].kind == ROW_PRED);
      if (dir_rows[r].kind == ROW_RESULT) begin
        cmd.key_first       = dir_rows[r].key[0];
        cmd.key_second      = dir_rows[r].key[1];
        cmd.key_third       = dir_rows[r].key[2];
        cmd.value_digits    = 31'(dir_rows[r].val);
        cmd.fraction_digits = 4'(dir_rows[r].frac);
        pending_cmds.push_back(cmd);
      end
    end

    // Random phases, each under its own length limit
    for (int p = 0; p < N_PHASE; p++) begin
      drain();
      if (p == 3) reg_access(1'b1, ADDR_UNMAPPED, 32'($urandom));
      reg_access(1'b1, ADDR_MAX_LEN, {28'($urandom), phase_len[p]});
      reg_access(1'b0, ADDR_MAX_LEN, '0);
      idle_pct = phase_idle[p];
      sent = 0;
      while (sent < phase_words[p]) begin
        make_frame(frame);
        foreach (frame[i]) send_word(frame[i], 1'b1);
        sent += frame.size();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
